FILE: hw/rtl/pngunf_pkg.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Shared widths, register and filter codes, and the types that pass between
// the control, reconstruction and register modules.
// ----------------------------------------------------------------------------
package pngunf_pkg;

  localparam int unsigned MAX_WIDTH_DEF    = 4096;
  localparam int unsigned MAX_CHANNELS_DEF = 4;

  localparam int COL_W    = 14;
  localparam int ROW_W    = 16;
  localparam int WIDTH_W  = 13;
  localparam int HEIGHT_W = 16;
  localparam int BPP_W    = 3;
  localparam int RB_W     = 16;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [7:0] FILT_NONE  = 8'd0;
  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BPP    = 2'd2;

  typedef struct packed {
    logic [WIDTH_W-1:0]  image_width;
    logic [HEIGHT_W-1:0] image_height;
    logic [BPP_W-1:0]    bytes_per_pixel;
  } pngunf_cfg_t;

  // One beat in the reconstruction stage.
  typedef struct packed {
    logic       is_sample;
    logic [7:0] data;
    logic [7:0] filter;
    logic [1:0] chan;
    logic       use_above;
    logic       in_store;
    logic       row_end;
    logic       image_end;
  } pngunf_beat_t;

endpackage

FILE: hw/rtl/pngunf_apb_regs.sv
// ----------------------------------------------------------------------------
// PNG unfilter configuration registers
// APB-style register file holding image width, height and bytes per pixel.
// ----------------------------------------------------------------------------
module pngunf_apb_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pngunf_pkg::ADDR_W-1:0]  paddr,
  input  logic [pngunf_pkg::DATA_W-1:0]  pwdata,
  output logic [pngunf_pkg::DATA_W-1:0]  prdata,
  output logic                           pready,
  output pngunf_pkg::pngunf_cfg_t        cfg
);
  import pngunf_pkg::*;

  logic [1:0] reg_sel;
  logic       wr_strobe;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[3:2];
  assign wr_strobe = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width     <= WIDTH_W'(1);
      cfg.image_height    <= HEIGHT_W'(1);
      cfg.bytes_per_pixel <= BPP_W'(1);
    end else if (wr_strobe) begin
      unique case (reg_sel)
        REG_WIDTH:  cfg.image_width     <= pwdata[WIDTH_W-1:0];
        REG_HEIGHT: cfg.image_height    <= pwdata[HEIGHT_W-1:0];
        REG_BPP:    cfg.bytes_per_pixel <= pwdata[BPP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = DATA_W'(cfg.image_width);
      REG_HEIGHT: prdata = DATA_W'(cfg.image_height);
      REG_BPP:    prdata = DATA_W'(cfg.bytes_per_pixel);
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/pngunf_line_store.sv
// ----------------------------------------------------------------------------
// PNG unfilter line store
// Single-port-write, registered-read memory that holds the row above.
// ----------------------------------------------------------------------------
module pngunf_line_store #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/pngunf_ctrl.sv
// ----------------------------------------------------------------------------
// PNG unfilter stream control
// Tracks filter bytes, column, channel and row, issues the line store read
// and loads the reconstruction stage.
// ----------------------------------------------------------------------------
module pngunf_ctrl #(
  parameter int unsigned MAX_WIDTH    = 4096,
  parameter int unsigned MAX_CHANNELS = 4,
  parameter int unsigned DEPTH        = 16384,
  parameter int unsigned AW           = 14
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pngunf_pkg::pngunf_cfg_t   cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                data_byte,
  input  logic                      image_start,
  input  logic                      stage_fire,
  output logic                      stage_valid,
  output pngunf_pkg::pngunf_beat_t  stage,
  output logic [AW-1:0]             stage_addr,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr
);
  import pngunf_pkg::*;

  logic [COL_W-1:0]    byte_column, byte_column_next;
  logic [1:0]          col_mod3, col_mod3_next;
  logic [ROW_W-1:0]    row_index, row_index_next;
  logic [7:0]          row_filter, row_filter_next;
  logic                awaiting, awaiting_next;

  logic                accept;
  logic [WIDTH_W-1:0]  width_eff;
  logic [BPP_W-1:0]    bpp_eff;
  logic [HEIGHT_W-1:0] height_last;
  logic [RB_W-1:0]     row_bytes;
  logic [COL_W-1:0]    col_cur, col_inc;
  logic [1:0]          mod3_cur;
  logic [ROW_W-1:0]    row_cur;
  logic                await_cur;
  logic [1:0]          chan;
  logic                in_store;
  logic                row_done, last_row;
  pngunf_beat_t        beat;

  assign in_ready = !stage_valid || stage_fire;
  assign accept   = in_valid && in_ready;

  // Clamp the registers to their legal ranges.
  always_comb begin
    if (cfg.image_width == '0) begin
      width_eff = WIDTH_W'(1);
    end else if (32'(cfg.image_width) > MAX_WIDTH) begin
      width_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      width_eff = cfg.image_width;
    end
    if (cfg.bytes_per_pixel == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (32'(cfg.bytes_per_pixel) > MAX_CHANNELS) begin
      bpp_eff = BPP_W'(MAX_CHANNELS);
    end else begin
      bpp_eff = cfg.bytes_per_pixel;
    end
    height_last = (cfg.image_height == '0) ? '0 : cfg.image_height - HEIGHT_W'(1);
    row_bytes   = RB_W'(width_eff) * RB_W'(bpp_eff);
  end

  // An image start restarts row and column before the beat is used.
  assign col_cur   = image_start ? '0 : byte_column;
  assign mod3_cur  = image_start ? '0 : col_mod3;
  assign row_cur   = image_start ? '0 : row_index;
  assign await_cur = image_start ? 1'b1 : awaiting;

  always_comb begin
    case (bpp_eff)
      3'd1:    chan = 2'd0;
      3'd2:    chan = {1'b0, col_cur[0]};
      3'd3:    chan = mod3_cur;
      default: chan = col_cur[1:0];
    endcase
  end

  assign in_store = 32'(col_cur) < DEPTH;
  assign col_inc  = col_cur + COL_W'(1);
  assign row_done = (RB_W'(col_inc) >= row_bytes) || (col_inc == '0);
  assign last_row = row_done && (row_cur >= height_last);

  always_comb begin
    byte_column_next = byte_column;
    col_mod3_next    = col_mod3;
    row_index_next   = row_index;
    row_filter_next  = row_filter;
    awaiting_next    = awaiting;
    beat.is_sample   = !await_cur;
    beat.data        = data_byte;
    beat.filter      = row_filter;
    beat.chan        = chan;
    beat.use_above   = (row_cur != '0) && in_store;
    beat.in_store    = in_store;
    beat.row_end     = row_done;
    beat.image_end   = last_row;
    if (accept) begin
      row_index_next = row_cur;
      if (await_cur) begin
        row_filter_next  = data_byte;
        awaiting_next    = 1'b0;
        byte_column_next = '0;
        col_mod3_next    = '0;
      end else if (row_done) begin
        byte_column_next = '0;
        col_mod3_next    = '0;
        awaiting_next    = 1'b1;
        row_index_next   = last_row ? '0 : row_cur + ROW_W'(1);
      end else begin
        byte_column_next = col_inc;
        col_mod3_next    = (mod3_cur == 2'd2) ? 2'd0 : mod3_cur + 2'd1;
        awaiting_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_column <= '0;
      col_mod3    <= '0;
      row_index   <= '0;
      row_filter  <= FILT_NONE;
      awaiting    <= 1'b1;
      stage_valid <= 1'b0;
    end else begin
      byte_column <= byte_column_next;
      col_mod3    <= col_mod3_next;
      row_index   <= row_index_next;
      row_filter  <= row_filter_next;
      awaiting    <= awaiting_next;
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (stage_fire) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage      <= beat;
      stage_addr <= AW'(col_cur);
    end
  end

  assign rd_en   = accept && !await_cur && in_store;
  assign rd_addr = AW'(col_cur);

endmodule

FILE: hw/rtl/pngunf_recon.sv
// ----------------------------------------------------------------------------
// PNG unfilter reconstruction stage
// Applies the row filter to one byte per unstalled cycle, keeps the left and
// above-left bytes per channel and holds the result in an output register.
// ----------------------------------------------------------------------------
module pngunf_recon #(
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      stage_valid,
  input  pngunf_pkg::pngunf_beat_t  stage,
  input  logic [7:0]                above_raw,
  output logic                      stage_fire,
  output logic                      wr_en,
  output logic [7:0]                wr_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                sample_value,
  output logic                      row_end,
  output logic                      image_end
);
  import pngunf_pkg::*;

  localparam int unsigned CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [7:0]      left_bytes [MAX_CHANNELS];
  logic [7:0]      above_left_bytes [MAX_CHANNELS];
  logic [CH_W-1:0] ch;
  logic [7:0]      a, b, c, pred, x;
  logic [8:0]      ab_sum;
  logic            take_sample;

  function automatic logic [7:0] paeth(input logic [7:0] pa_in, input logic [7:0] pb_in,
                                       input logic [7:0] pc_in);
    logic signed [9:0] sa, sb, sc, p, da, db, dc;
    sa = $signed({2'b00, pa_in});
    sb = $signed({2'b00, pb_in});
    sc = $signed({2'b00, pc_in});
    p  = sa + sb - sc;
    da = p - sa;
    db = p - sb;
    dc = p - sc;
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return pa_in;
    if (db <= dc) return pb_in;
    return pc_in;
  endfunction

  assign stage_fire  = stage_valid && (!stage.is_sample || !out_valid || out_ready);
  assign take_sample = stage_fire && stage.is_sample;

  assign ch     = stage.chan[CH_W-1:0];
  assign a      = left_bytes[ch];
  assign b      = stage.use_above ? above_raw : 8'd0;
  assign c      = above_left_bytes[ch];
  assign ab_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (stage.filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = 8'd0;
    endcase
    x = stage.data + pred;
  end

  assign wr_en   = take_sample && stage.in_store;
  assign wr_data = x;

  // A filter byte starts a row, so the neighbour history is cleared.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(MAX_CHANNELS); i++) begin
        left_bytes[i]       <= 8'd0;
        above_left_bytes[i] <= 8'd0;
      end
    end else if (stage_fire) begin
      if (stage.is_sample) begin
        left_bytes[ch]       <= x;
        above_left_bytes[ch] <= b;
      end else begin
        for (int i = 0; i < int'(MAX_CHANNELS); i++) begin
          left_bytes[i]       <= 8'd0;
          above_left_bytes[i] <= 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_sample) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_sample) begin
      sample_value <= x;
      row_end      <= stage.row_end;
      image_end    <= stage.image_end;
    end
  end

endmodule

FILE: hw/rtl/png_scanline_unfilter_top.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter, top level
// Rebuilds 8-bit PNG samples from the inflated, filtered byte stream.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) takes one stream byte per beat, with
// image_start marking the first byte of a new image. The first byte of every
// row is its filter type and gives no output; every later byte gives one
// output beat (out_valid/out_ready) with the rebuilt sample, a row_end flag on
// the last sample of a row and an image_end flag on the last sample of the
// image. The APB port holds width, height and bytes per pixel; write it only
// while no beat is in flight.
// The block sustains one input beat per cycle while out_ready stays high.
// An accepted sample is held in the stage register, next to the registered
// line store read, and then goes through the filter arithmetic into the
// output register. When the receiver stalls, the output register holds its
// beat and the reconstruction stage waits behind it, so at most two beats
// are buffered before in_ready drops. Reset clears the control state and
// neighbour bytes; the line store is not cleared, since each entry is
// written by a row before the next row reads it.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_top #(
  parameter int unsigned MAX_WIDTH    = pngunf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_CHANNELS = pngunf_pkg::MAX_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pngunf_pkg::ADDR_W-1:0] paddr,
  input  logic [pngunf_pkg::DATA_W-1:0] pwdata,
  output logic [pngunf_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          image_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    sample_value,
  output logic                          row_end,
  output logic                          image_end
);
  import pngunf_pkg::*;

  // The line store covers one full row of bytes at the largest width.
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pngunf_cfg_t  cfg;
  pngunf_beat_t stage;
  logic         stage_valid, stage_fire;
  logic [AW-1:0] stage_addr, rd_addr;
  logic         rd_en, wr_en;
  logic [7:0]   rd_data, wr_data;

  pngunf_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stream bookkeeping and the line store read for each sample.
  pngunf_ctrl #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .DEPTH        (DEPTH),
    .AW           (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .image_start (image_start),
    .stage_fire  (stage_fire),
    .stage_valid (stage_valid),
    .stage       (stage),
    .stage_addr  (stage_addr),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr)
  );

  // Within a row the columns are distinct, and a row's first sample is read
  // only after the filter byte has passed, so the write back of one sample
  // never meets the read of the same entry in one cycle.
  pngunf_line_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (stage_addr),
    .wr_data (wr_data)
  );

  pngunf_recon #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_recon (
    .clk          (clk),
    .rst          (rst),
    .stage_valid  (stage_valid),
    .stage        (stage),
    .above_raw    (rd_data),
    .stage_fire   (stage_fire),
    .wr_en        (wr_en),
    .wr_data      (wr_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_value (sample_value),
    .row_end      (row_end),
    .image_end    (image_end)
  );

endmodule

FILE: hw/rtl/pngunf_checker.sv
// ----------------------------------------------------------------------------
// PNG unfilter port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module pngunf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] sample_value,
  input logic       row_end,
  input logic       image_end
);

  // A stalled output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_value)
      && $stable(row_end) && $stable(image_end))
    else $error("output beat changed while stalled");

  // The last sample of the image is also the last sample of its row.
  a_image_end_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_end |-> row_end)
    else $error("image_end without row_end");

  // A fresh output beat comes from an accepted input beat via the stage register.
  a_out_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("output beat without a matching input beat");

  // Output is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind png_scanline_unfilter_top pngunf_checker u_checker (.*);
